/* hdl/bnft_pkg.sv */
`timescale 1ns / 1ps

package bnft_pkg;

    // default fraction width of the Q1.x fixed-point format
    localparam int FRAC_BITS_DEF = 14;

    // stage counts of the fixed parts of the pipeline
    localparam int CROSS_STAGES = 4;
    localparam int ROOT_BITS    = 16;
    localparam int SQRT_STAGES  = ROOT_BITS;
    localparam int OUT_STAGES   = 1;

    // output magnitude limit
    localparam logic [15:0] POS_MAX = 16'h7fff;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic               sign_negative;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] tangent_out_x;
        logic signed [15:0] tangent_out_y;
        logic signed [15:0] tangent_out_z;
        logic signed [15:0] binormal_x;
        logic signed [15:0] binormal_y;
        logic signed [15:0] binormal_z;
        logic               zero_length;
    } out_beat_t;

    // data that rides alongside the arithmetic lanes
    typedef struct packed {
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic [2:0]         negate;
        logic               zero_len;
    } side_t;

    // quotient bits of the per-component divide
    function automatic int div_stages(input int frac_bits);
        return 2 * frac_bits + 3;
    endfunction

endpackage

/* hdl/bnft_cross.sv */
`timescale 1ns / 1ps

module bnft_cross (
    input  logic                                  aclk,
    input  logic [bnft_pkg::CROSS_STAGES-1:0]     adv,
    input  bnft_pkg::in_beat_t                    in_beat,
    output logic [63:0]                           len_sq,
    output logic [2:0][61:0]                      mag_sq,
    output bnft_pkg::side_t                       side_out
);
    import bnft_pkg::*;

    // stage 1: partial products
    logic signed [31:0] prod_reg [6];
    side_t              side1_reg;
    // stage 2: cross components as magnitudes
    logic [30:0]        mag_reg [3];
    side_t              side2_reg;
    // stage 3: squares
    logic [61:0]        sq_reg [3];
    side_t              side3_reg;
    // stage 4: squared length
    logic [63:0]        len_reg;
    logic [61:0]        sq4_reg [3];
    side_t              side4_reg;

    logic signed [32:0] diff [3];
    logic signed [32:0] diff_neg [3];
    logic [30:0]        mag_next [3];
    side_t              side1_next;
    side_t              side2_next;
    side_t              side3_next;

    always_comb begin
        side1_next.tangent_x = in_beat.tangent_x;
        side1_next.tangent_y = in_beat.tangent_y;
        side1_next.tangent_z = in_beat.tangent_z;
        side1_next.negate    = {3{in_beat.sign_negative}};
        side1_next.zero_len  = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            prod_reg[0] <= in_beat.normal_y * in_beat.tangent_z;
            prod_reg[1] <= in_beat.normal_z * in_beat.tangent_y;
            prod_reg[2] <= in_beat.normal_z * in_beat.tangent_x;
            prod_reg[3] <= in_beat.normal_x * in_beat.tangent_z;
            prod_reg[4] <= in_beat.normal_x * in_beat.tangent_y;
            prod_reg[5] <= in_beat.normal_y * in_beat.tangent_x;
            side1_reg   <= side1_next;
        end
    end

    // component fits in 32 bits signed, magnitude below 2^31
    always_comb begin
        side2_next = side1_reg;
        for (int i = 0; i < 3; i++) begin
            diff[i]     = prod_reg[2*i] - prod_reg[2*i+1];
            diff_neg[i] = -diff[i];
            mag_next[i] = diff[i][32] ? diff_neg[i][30:0] : diff[i][30:0];
            side2_next.negate[i] = side1_reg.negate[i] ^ diff[i][32];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= mag_next[i];
            end
            side2_reg <= side2_next;
        end
    end

    always_comb begin
        side3_next          = side2_reg;
        side3_next.zero_len = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= mag_reg[i] * mag_reg[i];
            end
            side3_reg <= side3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            len_reg   <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            sq4_reg   <= sq_reg;
            side4_reg <= side3_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_sq[i] = sq4_reg[i];
        end
    end

    assign len_sq   = len_reg;
    assign side_out = side4_reg;

endmodule

/* hdl/bnft_div.sv */
`timescale 1ns / 1ps

module bnft_div #(
    parameter int FRAC_BITS = bnft_pkg::FRAC_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic [bnft_pkg::div_stages(FRAC_BITS)-1:0]    adv,
    input  logic [63:0]                                   len_sq,
    input  logic [2:0][61:0]                              mag_sq,
    input  bnft_pkg::side_t                               side_in,
    output logic [2:0][31:0]                              quo,
    output bnft_pkg::side_t                               side_out
);
    import bnft_pkg::*;

    // quotient of mag_sq * 2^(2F+2) / len_sq, one bit per stage, msb first
    localparam int QW  = div_stages(FRAC_BITS);
    localparam int QXW = (QW > 32) ? QW : 33;

    logic [2:0][64:0]    rem_reg [QW-1];
    logic [63:0]         len_reg [QW-1];
    logic [2:0][QW-1:0]  quo_reg [QW];
    side_t               side_reg [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [2:0][64:0]   rem_src;
        logic [2:0][QW-1:0] quo_src;
        logic [63:0]        len_src;
        side_t              side_src;
        logic [2:0][64:0]   rem_next;
        logic [2:0][QW-1:0] quo_next;
        logic [64:0]        diff;

        if (s == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    rem_src[l] = 65'(mag_sq[l]);
                end
            end
            assign quo_src  = '0;
            assign len_src  = len_sq;
            assign side_src = side_in;
        end else begin : g_rest
            assign rem_src  = rem_reg[s-1];
            assign quo_src  = quo_reg[s-1];
            assign len_src  = len_reg[s-1];
            assign side_src = side_reg[s-1];
        end

        // partial remainder stays below twice the divisor
        always_comb begin
            diff = '0;
            for (int l = 0; l < 3; l++) begin
                diff = rem_src[l] - {1'b0, len_src};
                if (rem_src[l] >= {1'b0, len_src}) begin
                    rem_next[l] = {diff[63:0], 1'b0};
                    quo_next[l] = {quo_src[l][QW-2:0], 1'b1};
                end else begin
                    rem_next[l] = {rem_src[l][63:0], 1'b0};
                    quo_next[l] = {quo_src[l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[s]) begin
                quo_reg[s]  <= quo_next;
                side_reg[s] <= side_src;
            end
        end

        if (s < QW - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (adv[s]) begin
                    rem_reg[s] <= rem_next;
                    len_reg[s] <= len_src;
                end
            end
        end
    end

    // clamp to 32 bits, enough to saturate the 16-bit root
    logic [QXW-1:0] quo_wide [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            quo_wide[l] = QXW'(quo_reg[QW-1][l]);
            quo[l]      = (|quo_wide[l][QXW-1:32]) ? 32'hffff_ffff : quo_wide[l][31:0];
        end
    end

    assign side_out = side_reg[QW-1];

endmodule

/* hdl/bnft_isqrt.sv */
`timescale 1ns / 1ps

module bnft_isqrt (
    input  logic                                 aclk,
    input  logic [bnft_pkg::SQRT_STAGES-1:0]     adv,
    input  logic [2:0][31:0]                     rad,
    input  bnft_pkg::side_t                      side_in,
    output logic [2:0][15:0]                     root,
    output bnft_pkg::side_t                      side_out
);
    import bnft_pkg::*;

    // digit-by-digit integer square root, one root bit per stage
    logic [2:0][31:0] rad_reg  [SQRT_STAGES-1];
    logic [2:0][16:0] rem_reg  [SQRT_STAGES-1];
    logic [2:0][15:0] root_reg [SQRT_STAGES];
    side_t            side_reg [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        logic [2:0][31:0] rad_src;
        logic [2:0][16:0] rem_src;
        logic [2:0][15:0] root_src;
        side_t            side_src;
        logic [2:0][16:0] rem_next;
        logic [2:0][15:0] root_next;
        logic [18:0]      rem_sh;
        logic [18:0]      trial;
        logic [18:0]      diff;

        if (s == 0) begin : g_first
            assign rad_src  = rad;
            assign rem_src  = '0;
            assign root_src = '0;
            assign side_src = side_in;
        end else begin : g_rest
            assign rad_src  = rad_reg[s-1];
            assign rem_src  = rem_reg[s-1];
            assign root_src = root_reg[s-1];
            assign side_src = side_reg[s-1];
        end

        always_comb begin
            rem_sh = '0;
            trial  = '0;
            diff   = '0;
            for (int l = 0; l < 3; l++) begin
                rem_sh = {rem_src[l], rad_src[l][31:30]};
                trial  = {1'b0, root_src[l], 2'b01};
                diff   = rem_sh - trial;
                if (rem_sh >= trial) begin
                    rem_next[l]  = diff[16:0];
                    root_next[l] = {root_src[l][14:0], 1'b1};
                end else begin
                    rem_next[l]  = rem_sh[16:0];
                    root_next[l] = {root_src[l][14:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[s]) begin
                root_reg[s] <= root_next;
                side_reg[s] <= side_src;
            end
        end

        if (s < SQRT_STAGES - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (adv[s]) begin
                    rem_reg[s] <= rem_next;
                    for (int l = 0; l < 3; l++) begin
                        rad_reg[s][l] <= {rad_src[l][29:0], 2'b00};
                    end
                end
            end
        end
    end

    assign root     = root_reg[SQRT_STAGES-1];
    assign side_out = side_reg[SQRT_STAGES-1];

endmodule

/* hdl/binormal_from_normal_tangent.sv */
// throughput: one beat per cycle unless a full pipeline stalls at the result;
// every stage is a register with its own valid bit
// a stalled result only holds the stages behind it that are full, bubbles still fill
// the depth is set by the bit-per-stage divider (2*FRAC_BITS + 3 stages) and root (16)
// reset: synchronous active-low aresetn clears the valid bits only, datapath is not reset
`timescale 1ns / 1ps

module binormal_from_normal_tangent #(
    parameter int FRAC_BITS = bnft_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bnft_pkg::in_beat_t    s_beat,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bnft_pkg::out_beat_t   m_beat
);
    import bnft_pkg::*;

    // stage map: cross product and length, divider, square root, output register
    localparam int QW       = div_stages(FRAC_BITS);
    localparam int DIV_BASE = CROSS_STAGES;
    localparam int SQ_BASE  = DIV_BASE + QW;
    localparam int OUT_IDX  = SQ_BASE + SQRT_STAGES;
    localparam int NSTAGE   = OUT_IDX + OUT_STAGES;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] adv;

    // a stage moves when some stage at or after it is empty, or the result is taken
    for (genvar i = 0; i < NSTAGE; i++) begin : g_adv
        assign adv[i] = m_ready || !(&valid_reg[NSTAGE-1:i]);
    end

    always_comb begin
        for (int i = 0; i < NSTAGE; i++) begin
            if (!adv[i]) begin
                valid_next[i] = valid_reg[i];
            end else if (i == 0) begin
                valid_next[i] = s_valid;
            end else begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = adv[0];
    assign m_valid = valid_reg[OUT_IDX];

    // cross product, magnitudes, squares and squared length
    logic [63:0]      len_sq;
    logic [2:0][61:0] mag_sq;
    side_t            side_cross;

    bnft_cross u_cross (
        .aclk     (aclk),
        .adv      (adv[CROSS_STAGES-1:0]),
        .in_beat  (s_beat),
        .len_sq   (len_sq),
        .mag_sq   (mag_sq),
        .side_out (side_cross)
    );

    // per-component c^2 * 2^(2F+2) / len_sq, clamped to 32 bits
    logic [2:0][31:0] quo;
    side_t            side_div;

    bnft_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .adv      (adv[DIV_BASE +: QW]),
        .len_sq   (len_sq),
        .mag_sq   (mag_sq),
        .side_in  (side_cross),
        .quo      (quo),
        .side_out (side_div)
    );

    // u = isqrt(quotient), the largest u with u^2 <= 4 * (|c| * 2^F)^2 / len_sq
    logic [2:0][15:0] root;
    side_t            side_sq;

    bnft_isqrt u_isqrt (
        .aclk     (aclk),
        .adv      (adv[SQ_BASE +: SQRT_STAGES]),
        .rad      (quo),
        .side_in  (side_div),
        .root     (root),
        .side_out (side_sq)
    );

    // round half away from zero: magnitude is (u + 1) / 2, at most 32768
    logic [16:0]        inc [3];
    logic [15:0]        mag [3];
    logic [15:0]        mag_neg [3];
    logic signed [15:0] comp [3];
    out_beat_t          out_next;
    out_beat_t          out_reg;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            inc[l]     = {1'b0, root[l]} + 17'd1;
            mag[l]     = inc[l][16:1];
            mag_neg[l] = 16'd0 - mag[l];
            if (side_sq.zero_len) begin
                comp[l] = '0;
            end else if (side_sq.negate[l]) begin
                comp[l] = mag_neg[l];
            end else if (mag[l][15]) begin
                comp[l] = POS_MAX;
            end else begin
                comp[l] = mag[l];
            end
        end
        out_next.tangent_out_x = side_sq.tangent_x;
        out_next.tangent_out_y = side_sq.tangent_y;
        out_next.tangent_out_z = side_sq.tangent_z;
        out_next.binormal_x    = comp[0];
        out_next.binormal_y    = comp[1];
        out_next.binormal_z    = comp[2];
        out_next.zero_length   = side_sq.zero_len;
    end

    always_ff @(posedge aclk) begin
        if (adv[OUT_IDX]) begin
            out_reg <= out_next;
        end
    end

    assign m_beat = out_reg;

    // an accepted beat always lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[0])
        else $error("accepted beat not captured in first stage");

    // a completely full pipeline with a stalled result takes nothing
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&valid_reg) && !m_ready) |-> !s_ready)
        else $error("input accepted while pipeline full and stalled");

    // zero length carries a zero binormal
    a_zero_binormal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_beat.zero_length) |->
            (m_beat.binormal_x == '0 && m_beat.binormal_y == '0 && m_beat.binormal_z == '0))
        else $error("zero-length result with nonzero binormal");

    // the largest normalized component is at least 1/sqrt(3), never rounds to zero
    a_unit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_beat.zero_length) |->
            (m_beat.binormal_x != '0 || m_beat.binormal_y != '0 || m_beat.binormal_z != '0))
        else $error("normalized binormal is all zero");

    // nothing moves out of the output register while it is stalled
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_reg)))
        else $error("stalled result changed");

endmodule

/* tb/sv/binormal_from_normal_tangent_tb.sv */
`timescale 1ns / 1ps

module binormal_from_normal_tangent_tb;

    import bnft_pkg::*;

    // fraction width the block is built with, the predictor uses the same
    localparam int FB = FRAC_BITS_DEF;

    // pipeline depth is 2*FRAC_BITS + 24, wait a bit longer once the queue drains
    localparam int DRAIN_CYCLES = 2 * FB + 40;

    // far above the slowest legal run of this many beats
    localparam int CYCLE_LIMIT  = 200000;

    localparam int N_RANDOM     = 531;
    localparam int N_DIRECTED   = 21;

    // directed rows: expectation typed in only where it is obvious
    typedef struct {
        in_beat_t  vtx;
        bit        typed;
        out_beat_t want;
    } vertex_case_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_beat  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_beat;

    // expected result beats, oldest first
    out_beat_t binormal_due[$];

    int  src_idle     = 0;
    int  snk_idle     = 0;
    int  beats_sent   = 0;
    int  beats_seen   = 0;
    int  zero_len_cnt = 0;
    int  errors       = 0;
    int  cycles       = 0;

    vertex_case_t directed_cases [0:N_DIRECTED-1] = '{
        // all zero, both signs: zero length flagged
        '{'{0, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0, 1}},
        '{'{0, 0, 0, 0, 0, 0, 1}, 1'b1, '{0, 0, 0, 0, 0, 0, 1}},
        // unit axes, x cross y gives z, sign flips it
        '{'{16384, 0, 0, 0, 16384, 0, 0}, 1'b1, '{0, 16384, 0, 0, 0, 16384, 0}},
        '{'{16384, 0, 0, 0, 16384, 0, 1}, 1'b1, '{0, 16384, 0, 0, 0, -16384, 0}},
        '{'{0, 16384, 0, 0, 0, 16384, 0}, 1'b1, '{0, 0, 16384, 16384, 0, 0, 0}},
        '{'{0, 0, 16384, 16384, 0, 0, 0}, 1'b1, '{16384, 0, 0, 0, 16384, 0, 0}},
        '{'{16384, 0, 0, 0, -16384, 0, 0}, 1'b1, '{0, -16384, 0, 0, 0, -16384, 0}},
        // parallel vectors: cross product vanishes
        '{'{16384, 16384, 16384, 16384, 16384, 16384, 0}, 1'b1,
          '{16384, 16384, 16384, 0, 0, 0, 1}},
        '{'{-32768, -32768, -32768, -32768, -32768, -32768, 1}, 1'b1,
          '{-32768, -32768, -32768, 0, 0, 0, 1}},
        '{'{32767, 32767, 32767, -32768, -32768, -32768, 0}, 1'b1,
          '{-32768, -32768, -32768, 0, 0, 0, 1}},
        // most negative and most positive codes on single axes
        '{'{-32768, 0, 0, 0, -32768, 0, 0}, 1'b1, '{0, -32768, 0, 0, 0, 16384, 0}},
        '{'{32767, 0, 0, 0, 32767, 0, 0}, 1'b1, '{0, 32767, 0, 0, 0, 16384, 0}},
        '{'{0, -32768, 0, 0, 0, 32767, 1}, 1'b1, '{0, 0, 32767, 16384, 0, 0, 0}},
        // the rest go through the predictor
        '{'{1, 0, 0, 0, 1, 0, 0}, 1'b0, '0},
        '{'{1, 2, 3, -3, 5, -7, 0}, 1'b0, '0},
        '{'{21845, -21846, 21845, -21846, 21845, 21845, 1}, 1'b0, '0},
        '{'{11585, 11585, 0, 0, 0, 16384, 0}, 1'b0, '0},
        '{'{32767, -32768, 1, -1, 32767, -32768, 1}, 1'b0, '0},
        '{'{-1, -1, -1, 1, -1, 0, 0}, 1'b0, '0},
        '{'{9459, 9459, 9459, -11585, 0, 11585, 1}, 1'b0, '0},
        '{'{3, 0, 0, 0, 2, 1, 0}, 1'b0, '0}
    };

    binormal_from_normal_tangent dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_beat  (s_beat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_beat  (m_beat)
    );

    always #10 aclk = ~aclk;

    // one output lane: round(|c| * 2^FB / sqrt(len2)), ties away from zero,
    // found by bisection on (2k-1)^2 * len2 <= 4 * c^2 * 2^(2*FB)
    function automatic logic [15:0] unit_component(input longint c, input bit flip,
                                                   input logic [63:0] len2);
        logic [63:0]  mag;
        logic [127:0] bound;
        logic [127:0] probe;
        logic [127:0] odd_sq;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        bit           negative;
        mag      = (c < 0) ? -c : c;
        negative = (c < 0) ^ flip;
        if (mag == 0 || len2 == 0)
            return 16'h0000;
        bound = {64'h0, mag * mag} << (2 * FB + 2);
        lo    = 0;
        hi    = 32768;
        while (lo < hi) begin
            mid    = (lo + hi + 1) >> 1;
            odd_sq = 128'(2 * mid - 1);
            odd_sq = odd_sq * odd_sq;
            probe  = odd_sq * 128'(len2);
            if (probe <= bound)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (lo == 0)
            return 16'h0000;
        if (!negative)
            return (lo > 32767) ? POS_MAX : lo[15:0];
        return 16'(64'd0 - lo);
    endfunction

    // full result beat for one vertex
    function automatic out_beat_t binormal_of(input in_beat_t v);
        out_beat_t r;
        longint    nx;
        longint    ny;
        longint    nz;
        longint    tx;
        longint    ty;
        longint    tz;
        longint    cr [3];
        logic [63:0] len2;
        nx = longint'(v.normal_x);
        ny = longint'(v.normal_y);
        nz = longint'(v.normal_z);
        tx = longint'(v.tangent_x);
        ty = longint'(v.tangent_y);
        tz = longint'(v.tangent_z);
        // exact cross product at scale 2^(2*FB)
        cr[0] = ny * tz - nz * ty;
        cr[1] = nz * tx - nx * tz;
        cr[2] = nx * ty - ny * tx;
        len2  = 64'd0;
        for (int i = 0; i < 3; i++)
            len2 += cr[i] * cr[i];
        r.tangent_out_x = v.tangent_x;
        r.tangent_out_y = v.tangent_y;
        r.tangent_out_z = v.tangent_z;
        r.binormal_x    = unit_component(cr[0], v.sign_negative, len2);
        r.binormal_y    = unit_component(cr[1], v.sign_negative, len2);
        r.binormal_z    = unit_component(cr[2], v.sign_negative, len2);
        r.zero_length   = (len2 == 0);
        return r;
    endfunction

    // random vertex drawn from a few shapes of interest
    function automatic in_beat_t random_vertex();
        in_beat_t v;
        int       kind;
        kind            = $urandom_range(99);
        v.sign_negative = 1'($urandom_range(1));
        v.normal_x      = 16'($urandom);
        v.normal_y      = 16'($urandom);
        v.normal_z      = 16'($urandom);
        v.tangent_x     = 16'($urandom);
        v.tangent_y     = 16'($urandom);
        v.tangent_z     = 16'($urandom);
        if (kind < 40) begin
            // full-range bit patterns, nothing more to do
        end else if (kind < 60) begin
            // tiny components: rounding ties and coarse directions
            v.normal_x  = 16'($urandom_range(8) - 4);
            v.normal_y  = 16'($urandom_range(8) - 4);
            v.normal_z  = 16'($urandom_range(8) - 4);
            v.tangent_x = 16'($urandom_range(8) - 4);
            v.tangent_y = 16'($urandom_range(8) - 4);
            v.tangent_z = 16'($urandom_range(8) - 4);
        end else if (kind < 75) begin
            // parallel or anti-parallel: zero length
            if ($urandom_range(1)) begin
                v.tangent_x = v.normal_x;
                v.tangent_y = v.normal_y;
                v.tangent_z = v.normal_z;
            end else begin
                v.tangent_x = -v.normal_x;
                v.tangent_y = -v.normal_y;
                v.tangent_z = -v.normal_z;
            end
        end else if (kind < 85) begin
            // one of the two vectors is zero
            if ($urandom_range(1)) begin
                v.normal_x = 0;
                v.normal_y = 0;
                v.normal_z = 0;
            end else begin
                v.tangent_x = 0;
                v.tangent_y = 0;
                v.tangent_z = 0;
            end
        end else begin
            // components from -16384 to 16384, unit-range inputs as a mesh would send them
            v.normal_x  = 16'($urandom_range(32768) - 16384);
            v.normal_y  = 16'($urandom_range(32768) - 16384);
            v.normal_z  = 16'($urandom_range(32768) - 16384);
            v.tangent_x = 16'($urandom_range(32768) - 16384);
            v.tangent_y = 16'($urandom_range(32768) - 16384);
            v.tangent_z = 16'($urandom_range(32768) - 16384);
        end
        return v;
    endfunction

    // offer one vertex beat, maybe after a random gap, and log its result once taken
    task automatic offer_vertex(input in_beat_t v, input out_beat_t want);
        if ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < src_idle);
        end
        s_valid <= 1'b1;
        s_beat  <= v;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // accepted at this edge
        binormal_due = {binormal_due, want};
        beats_sent++;
    endtask

    // stimulus and end of run
    initial begin
        in_beat_t v;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows run under the first idling mix
        src_idle = 6;
        snk_idle = 62;
        for (int i = 0; i < N_DIRECTED; i++) begin
            v = directed_cases[i].vtx;
            if (directed_cases[i].typed)
                offer_vertex(v, directed_cases[i].want);
            else
                offer_vertex(v, binormal_of(v));
        end

        // random part in three mixes: sender light / receiver heavy, swapped, none
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle = 6;
                    snk_idle = 62;
                end
                1: begin
                    src_idle = 62;
                    snk_idle = 6;
                end
                default: begin
                    src_idle = 0;
                    snk_idle = 0;
                end
            endcase
            for (int i = 0; i < N_RANDOM / 3; i++) begin
                v = random_vertex();
                offer_vertex(v, binormal_of(v));
            end
        end
        s_valid <= 1'b0;

        // let everything drain, then watch for stray beats
        while (binormal_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d vertex beats (%0d directed, rest random) under three idle mixes",
                 beats_sent, N_DIRECTED);
        $display("%0d result beats compared, %0d of them flagged zero length",
                 beats_seen, zero_len_cnt);
        if (errors == 0 && binormal_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // receiver: compare each result beat with the oldest expectation, then
    // pick the next ready level
    always @(posedge aclk) begin : result_check
        out_beat_t want;
        bit        bad;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (m_beat.zero_length)
                zero_len_cnt++;
            if (binormal_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result beat with nothing expected: binormal %0d %0d %0d",
                             m_beat.binormal_x, m_beat.binormal_y, m_beat.binormal_z);
            end else begin
                want = binormal_due.pop_front();
                bad  = 1'b0;
                if (m_beat.tangent_out_x !== want.tangent_out_x) bad = 1'b1;
                if (m_beat.tangent_out_y !== want.tangent_out_y) bad = 1'b1;
                if (m_beat.tangent_out_z !== want.tangent_out_z) bad = 1'b1;
                if (m_beat.binormal_x    !== want.binormal_x)    bad = 1'b1;
                if (m_beat.binormal_y    !== want.binormal_y)    bad = 1'b1;
                if (m_beat.binormal_z    !== want.binormal_z)    bad = 1'b1;
                if (m_beat.zero_length   !== want.zero_length)   bad = 1'b1;
                if (bad) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch on result beat %0d", beats_seen);
                        $display("  expected t %0d %0d %0d  b %0d %0d %0d  zero %0d",
                                 want.tangent_out_x, want.tangent_out_y,
                                 want.tangent_out_z, want.binormal_x,
                                 want.binormal_y, want.binormal_z, want.zero_length);
                        $display("  actual   t %0d %0d %0d  b %0d %0d %0d  zero %0d",
                                 m_beat.tangent_out_x, m_beat.tangent_out_y,
                                 m_beat.tangent_out_z, m_beat.binormal_x,
                                 m_beat.binormal_y, m_beat.binormal_z, m_beat.zero_length);
                    end
                end
            end
        end
        m_ready <= ($urandom_range(99) >= snk_idle);
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, binormal_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

/* filelist.f */
hdl/bnft_pkg.sv
hdl/bnft_cross.sv
hdl/bnft_div.sv
hdl/bnft_isqrt.sv
hdl/binormal_from_normal_tangent.sv
tb/sv/binormal_from_normal_tangent_tb.sv
